/* design/smx_pkg.sv */
`timescale 1ns / 1ps
// smx_pkg: shared constants, types and codes for the stale-gated axis mixer
// used by every module of the block, depends on nothing

package smx_pkg;

  localparam int NUM_SOURCES = 3;
  localparam int NUM_AXES    = 6;
  localparam int AGE_BITS    = 10;
  localparam int VALUE_BITS  = 16;

  localparam int IO_AXES      = 6;
  localparam int IO_BITS      = 16;
  localparam int CFG_BITS     = 10;
  localparam int PERIOD_BITS  = 10;
  localparam int SRC_BITS     = 2;
  localparam int SRC_IDX_BITS = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int SUM_BITS     = VALUE_BITS + $clog2(NUM_SOURCES) + 1;
  localparam int Q_ONE        = 16384;

  localparam logic [AGE_BITS-1:0] AGE_TOP = {AGE_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] MAX_AGE_RESET = CFG_BITS'(100);
  localparam logic [CFG_BITS-1:0] PERIOD_RESET  = CFG_BITS'(50);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic {
    REG_MAX_AGE = 1'b0,
    REG_PERIOD  = 1'b1
  } reg_idx_t;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef value_t [NUM_AXES-1:0]        axes_t;
  typedef axes_t [NUM_SOURCES-1:0]      store_t;
  typedef logic signed [IO_BITS-1:0]    io_t;
  typedef io_t [IO_AXES-1:0]            mix_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  typedef struct packed {
    logic                   emit;
    logic [NUM_SOURCES-1:0] fresh;
  } track_ctl_t;

endpackage

/* design/smx_track.sv */
`timescale 1ns / 1ps
// smx_track: source value store, source ages, period counter and config registers
// depends on smx_pkg

module smx_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [smx_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          accept,
  input  logic                          operation,
  input  logic [smx_pkg::SRC_BITS-1:0]  source,
  input  smx_pkg::mix_t                 in_axes,
  output smx_pkg::store_t               vals,
  output smx_pkg::track_ctl_t           ctl
);
  import smx_pkg::*;

  logic [CFG_BITS-1:0]    max_age;
  logic [CFG_BITS-1:0]    period;
  logic [PERIOD_BITS-1:0] period_count;
  logic [AGE_BITS-1:0]    ages [NUM_SOURCES];

  logic [AGE_BITS-1:0]    ages_next [NUM_SOURCES];
  logic [PERIOD_BITS-1:0] period_count_next;
  logic [CFG_BITS-1:0]    period_eff;
  logic                   is_tick;
  logic                   src_ok;
  axes_t                  upd_axes;

  assign is_tick    = (op_t'(operation) == OP_TICK);
  assign src_ok     = (int'(source) < NUM_SOURCES);
  assign period_eff = (period == '0) ? CFG_BITS'(1) : period;
  assign period_count_next = period_count + PERIOD_BITS'(1);

  always_comb begin
    for (int s = 0; s < NUM_SOURCES; s++) begin
      ages_next[s] = (ages[s] < AGE_TOP) ? ages[s] + AGE_BITS'(1) : ages[s];
      ctl.fresh[s] = (int'(ages_next[s]) < int'(max_age));
    end
    ctl.emit = is_tick && (CFG_BITS'(period_count_next) >= period_eff);
    for (int a = 0; a < NUM_AXES; a++) begin
      upd_axes[a] = (a < IO_AXES) ? value_t'(in_axes[a]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age      <= MAX_AGE_RESET;
      period       <= PERIOD_RESET;
      period_count <= '0;
      vals         <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) ages[s] <= AGE_TOP;
    end else begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_AGE: max_age <= cfg_data;
          REG_PERIOD:  period  <= cfg_data;
          default:     ;
        endcase
      end
      if (accept) begin
        if (is_tick) begin
          for (int s = 0; s < NUM_SOURCES; s++) ages[s] <= ages_next[s];
          period_count <= ctl.emit ? '0 : period_count_next;
        end else if (src_ok) begin
          vals[source[SRC_IDX_BITS-1:0]] <= upd_axes;
          ages[source[SRC_IDX_BITS-1:0]] <= '0;
        end
      end
    end
  end

endmodule

/* design/smx_mix.sv */
`timescale 1ns / 1ps
// smx_mix: per-axis sum of fresh source values with clamp to plus or minus one
// depends on smx_pkg

module smx_mix (
  input  smx_pkg::store_t      vals,
  input  smx_pkg::track_ctl_t  ctl,
  output smx_pkg::mix_t        mix
);
  import smx_pkg::*;

  localparam sum_t SUM_POS = sum_t'(Q_ONE);
  localparam sum_t SUM_NEG = -sum_t'(Q_ONE);

  sum_t sum [IO_AXES];

  always_comb begin
    for (int a = 0; a < IO_AXES; a++) begin
      sum[a] = '0;
      if (a < NUM_AXES) begin
        for (int s = 0; s < NUM_SOURCES; s++) begin
          if (ctl.fresh[s]) sum[a] = sum[a] + sum_t'($signed(vals[s][a]));
        end
      end
      if (sum[a] > SUM_POS) begin
        mix[a] = io_t'(SUM_POS);
      end else if (sum[a] < SUM_NEG) begin
        mix[a] = io_t'(SUM_NEG);
      end else begin
        mix[a] = io_t'(sum[a]);
      end
    end
  end

endmodule

/* design/smx_skid.sv */
`timescale 1ns / 1ps
// smx_skid: two-entry result buffer, output register plus one spare slot
// depends on smx_pkg

module smx_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  smx_pkg::mix_t  push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output smx_pkg::mix_t  out_data
);
  import smx_pkg::*;

  logic main_v;
  logic spare_v;
  mix_t spare;
  logic pop;

  assign pop       = main_v && !out_stall;
  assign full      = spare_v;
  assign out_valid = main_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v  <= 1'b0;
      spare_v <= 1'b0;
    end else if (pop) begin
      if (spare_v) begin
        out_data <= spare;
        spare_v  <= push;
        if (push) spare <= push_data;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        main_v <= 1'b0;
      end
    end else if (push) begin
      if (!main_v) begin
        out_data <= push_data;
        main_v   <= 1'b1;
      end else begin
        spare   <= push_data;
        spare_v <= 1'b1;
      end
    end
  end

endmodule

/* design/stale_gated_axis_mixer_core.sv */
`timescale 1ns / 1ps
// stale_gated_axis_mixer_core: top level, one beat accepted per cycle while in_stall is low
// a period-ending tick pushes its result into the result buffer, which drives out_valid
// throughput: one input beat per cycle unless in_stall is high, with the state updated on each accepted beat
// results pass a two-entry buffer, input stalls only when both slots hold results
// reset: synchronous; ages go stale, values and period count clear, registers 100 and 50
// depends on smx_pkg, smx_track, smx_mix, smx_skid

module stale_gated_axis_mixer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [smx_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [smx_pkg::SRC_BITS-1:0]  source,
  input  logic signed [15:0]            lin_x,
  input  logic signed [15:0]            lin_y,
  input  logic signed [15:0]            lin_z,
  input  logic signed [15:0]            rot_a,
  input  logic signed [15:0]            rot_b,
  input  logic signed [15:0]            rot_c,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            mix_x,
  output logic signed [15:0]            mix_y,
  output logic signed [15:0]            mix_z,
  output logic signed [15:0]            mix_a,
  output logic signed [15:0]            mix_b,
  output logic signed [15:0]            mix_c
);
  import smx_pkg::*;

  logic       accept;
  mix_t       in_axes;
  store_t     vals;
  track_ctl_t ctl;
  mix_t       mix;
  mix_t       out_data;

  assign accept = in_valid && !in_stall;
  assign in_axes[0] = lin_x;
  assign in_axes[1] = lin_y;
  assign in_axes[2] = lin_z;
  assign in_axes[3] = rot_a;
  assign in_axes[4] = rot_b;
  assign in_axes[5] = rot_c;

  smx_track u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .operation (operation),
    .source    (source),
    .in_axes   (in_axes),
    .vals      (vals),
    .ctl       (ctl)
  );

  smx_mix u_mix (
    .vals (vals),
    .ctl  (ctl),
    .mix  (mix)
  );

  smx_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && ctl.emit),
    .push_data (mix),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign mix_x = out_data[0];
  assign mix_y = out_data[1];
  assign mix_z = out_data[2];
  assign mix_a = out_data[3];
  assign mix_b = out_data[4];
  assign mix_c = out_data[5];

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result buffer not empty after reset");

  a_update_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (op_t'(operation) == OP_UPDATE) && !out_valid) |=> !out_valid)
    else $error("update beat produced a result");

  a_emit_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (op_t'(operation) == OP_TICK))
    else $error("emit flagged on a non-tick beat");
`endif

endmodule
